// ===== hdl/ple_pkg.sv =====
// Shared types and constants of the paged list engine.
`timescale 1ns / 1ps
package ple_pkg;

    localparam int DEF_PAGE_ITEMS = 16;
    localparam int DEF_MAX_PAGES  = 16;
    localparam int DEF_ITEM_WIDTH = 32;

    localparam int POS_W = 9;
    localparam int CNT_W = 9;
    localparam int PGC_W = 5;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [2:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_READ     = 3'd3,
        OP_TRUNCATE = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_APPEND, S_LOCATE, S_RDA, S_RDB, S_DEL_FIN,
        S_INS_CHK, S_EVEN, S_EVEN2, S_EVEN_FIN, S_SPLIT_CHK, S_SPLIT,
        S_SPLIT_FIN, S_INS_SHIFT, S_INS_FIN, S_MV_RD, S_MV_WR, S_TRUNC, S_DONE
    } state_t;

endpackage

// ===== hdl/paged_list_engine_top.sv =====
// Paged list engine: word list in fixed pages, run by a sequencer over one store.
`timescale 1ns / 1ps
//  channel   | handshake                 | words
//  ----------+---------------------------+---------------------------------------
//  command   | start / busy              | op, position, item_value
//  result    | done (one-cycle strobe)   | ok, read_value, item_count, pages_in_use
//  config    | cfg_valid / cfg_ready     | cfg_data (page_items)
//
//  A command runs its decode and range checks, then steps one page at a time while
//  locating the position, and moves each word through the page store with one read
//  and one write, closing each block move with a final step; an insert that balances
//  and splits moves at most about 2 * PAGE_ITEMS words.
//  Reset is asynchronous and active low; no clearing pass, since store words are
//  only read once written. The result cannot be stalled: it shows for one cycle
//  and busy drops in the cycle after it. Config writes are always taken.
module paged_list_engine_top #(
    parameter int PAGE_ITEMS = ple_pkg::DEF_PAGE_ITEMS,
    parameter int MAX_PAGES  = ple_pkg::DEF_MAX_PAGES,
    parameter int ITEM_WIDTH = ple_pkg::DEF_ITEM_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 op,
    input  logic [ple_pkg::POS_W-1:0]  position,
    input  logic [ITEM_WIDTH-1:0]      item_value,
    output logic                       done,
    output logic                       ok,
    output logic [ITEM_WIDTH-1:0]      read_value,
    output logic [ple_pkg::CNT_W-1:0]  item_count,
    output logic [ple_pkg::PGC_W-1:0]  pages_in_use,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ple_pkg::CFG_W-1:0]  cfg_data
);

    localparam int FW   = $clog2(PAGE_ITEMS + 1);          // fill count
    localparam int IW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW   = $clog2(MAX_PAGES + 1);           // pages in use
    localparam int AW   = $clog2(MAX_PAGES * PAGE_ITEMS);
    localparam int TW   = $clog2(MAX_PAGES * PAGE_ITEMS + 1);
    localparam int PosW = (TW > ple_pkg::POS_W) ? TW : ple_pkg::POS_W;

    // state
    ple_pkg::state_t state_reg, state_next;
    ple_pkg::state_t mv_ret_reg, mv_ret_next;

    logic [ple_pkg::CFG_W-1:0] cfg_reg;
    logic [2:0]                op_reg, op_next;
    logic [PosW-1:0]           pos_reg, pos_next;
    logic [ITEM_WIDTH-1:0]     val_reg, val_next;
    logic [IW-1:0]             p_reg, p_next;
    logic [PosW-1:0]           trc_reg, trc_next;
    logic [PosW-1:0]           total_reg, total_next;
    logic [CW-1:0]             pu_reg, pu_next;
    logic                      ok_reg, ok_next;
    logic [ITEM_WIDTH-1:0]     rd_reg, rd_next;

    logic [FW-1:0] fill_reg  [MAX_PAGES];
    logic [FW-1:0] fill_next [MAX_PAGES];
    logic [IW-1:0] order_reg  [MAX_PAGES];
    logic [IW-1:0] order_next [MAX_PAGES];

    // word mover
    logic [FW-1:0] mv_cnt_reg, mv_cnt_next;
    logic [IW-1:0] mv_sp_reg, mv_sp_next, mv_dp_reg, mv_dp_next;
    logic [FW-1:0] mv_si_reg, mv_si_next, mv_di_reg, mv_di_next;
    logic          mv_dec_reg, mv_dec_next;

    // page store
    logic [ITEM_WIDTH-1:0] mem [MAX_PAGES * PAGE_ITEMS];
    logic [ITEM_WIDTH-1:0] mem_q;
    logic [AW-1:0]         raddr, waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic                  we;

    function automatic logic [AW-1:0] slot_addr(input logic [IW-1:0] phys,
                                                input logic [FW-1:0] idx);
        return AW'(int'(phys) * PAGE_ITEMS + int'(idx));
    endfunction

    // conditions
    logic [FW-1:0] eff, fill_p, fill_p1, fill_last, n_even, half, rest;
    logic [FW:0]   pair_sum;
    logic [IW-1:0] p1, last_ix;
    logic [PosW-1:0] tr_sum;
    logic p_has_next, loc_step, app_need, pool_full, tr_stop, pos_ge_total;

    always_comb
    begin
        if (cfg_reg == '0)
            eff = FW'(1);
        else if (32'(cfg_reg) > PAGE_ITEMS)
            eff = FW'(PAGE_ITEMS);
        else
            eff = FW'(cfg_reg);
        p1         = IW'(p_reg + 1'b1);
        last_ix    = IW'(pu_reg - 1'b1);
        fill_p     = fill_reg[p_reg];
        fill_p1    = fill_reg[p1];
        fill_last  = fill_reg[last_ix];
        pair_sum   = (FW+1)'(fill_p) + (FW+1)'(fill_p1);
        n_even     = FW'(pair_sum >> 1);
        half       = fill_p >> 1;
        rest       = fill_p - half;
        p_has_next = (CW'(p_reg) + CW'(1)) < pu_reg;
        loc_step   = p_has_next && (pos_reg >= PosW'(fill_p));
        app_need   = (pu_reg == '0) || (fill_last >= eff);
        pool_full  = 32'(pu_reg) >= MAX_PAGES;
        tr_sum     = trc_reg + PosW'(fill_p);
        tr_stop    = (tr_sum >= pos_reg) || !p_has_next;
        pos_ge_total = pos_reg >= total_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::S_IDLE:
                if (start) state_next = ple_pkg::S_DECODE;
            ple_pkg::S_DECODE:
                case (op_reg)
                    ple_pkg::OP_APPEND: state_next = ple_pkg::S_APPEND;
                    ple_pkg::OP_INSERT:
                        state_next = pos_ge_total ? ple_pkg::S_APPEND : ple_pkg::S_LOCATE;
                    ple_pkg::OP_DELETE:
                        state_next = pos_ge_total ? ple_pkg::S_DONE : ple_pkg::S_LOCATE;
                    ple_pkg::OP_READ:
                        state_next = (total_reg == '0) ? ple_pkg::S_DONE : ple_pkg::S_LOCATE;
                    ple_pkg::OP_TRUNCATE:
                        state_next = pos_ge_total ? ple_pkg::S_DONE : ple_pkg::S_TRUNC;
                    default: state_next = ple_pkg::S_DONE;
                endcase
            ple_pkg::S_APPEND:
                if (!(app_need && !pool_full)) state_next = ple_pkg::S_DONE;
            ple_pkg::S_LOCATE:
                if (!loc_step)
                begin
                    if (op_reg == ple_pkg::OP_READ)
                        state_next = ple_pkg::S_RDA;
                    else if (op_reg == ple_pkg::OP_DELETE)
                        state_next = ple_pkg::S_MV_RD;
                    else
                        state_next = ple_pkg::S_INS_CHK;
                end
            ple_pkg::S_RDA:      state_next = ple_pkg::S_RDB;
            ple_pkg::S_RDB:      state_next = ple_pkg::S_DONE;
            ple_pkg::S_MV_RD:
                state_next = (mv_cnt_reg == '0) ? mv_ret_reg : ple_pkg::S_MV_WR;
            ple_pkg::S_MV_WR:    state_next = ple_pkg::S_MV_RD;
            ple_pkg::S_DEL_FIN:  state_next = ple_pkg::S_DONE;
            ple_pkg::S_INS_CHK:
                if (fill_p >= eff)
                    state_next = p_has_next ? ple_pkg::S_EVEN : ple_pkg::S_SPLIT_CHK;
                else
                    state_next = ple_pkg::S_INS_SHIFT;
            ple_pkg::S_EVEN:
                state_next = (n_even == fill_p) ? ple_pkg::S_EVEN_FIN : ple_pkg::S_MV_RD;
            ple_pkg::S_EVEN2:    state_next = ple_pkg::S_MV_RD;
            ple_pkg::S_EVEN_FIN: state_next = ple_pkg::S_SPLIT_CHK;
            ple_pkg::S_SPLIT_CHK:
                if (fill_p >= eff)
                    state_next = pool_full ? ple_pkg::S_DONE : ple_pkg::S_SPLIT;
                else
                    state_next = ple_pkg::S_INS_SHIFT;
            ple_pkg::S_SPLIT:     state_next = ple_pkg::S_MV_RD;
            ple_pkg::S_SPLIT_FIN: state_next = ple_pkg::S_INS_SHIFT;
            ple_pkg::S_INS_SHIFT:
                state_next = (32'(fill_p) >= PAGE_ITEMS) ? ple_pkg::S_DONE
                                                         : ple_pkg::S_MV_RD;
            ple_pkg::S_INS_FIN:  state_next = ple_pkg::S_DONE;
            ple_pkg::S_TRUNC:
                if (tr_stop) state_next = ple_pkg::S_DONE;
            ple_pkg::S_DONE:     state_next = ple_pkg::S_IDLE;
            default:             state_next = ple_pkg::S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        p_next      = p_reg;
        trc_next    = trc_reg;
        total_next  = total_reg;
        pu_next     = pu_reg;
        ok_next     = ok_reg;
        rd_next     = rd_reg;
        mv_ret_next = mv_ret_reg;
        mv_cnt_next = mv_cnt_reg;
        mv_sp_next  = mv_sp_reg;
        mv_si_next  = mv_si_reg;
        mv_dp_next  = mv_dp_reg;
        mv_di_next  = mv_di_reg;
        mv_dec_next = mv_dec_reg;
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            fill_next[i]  = fill_reg[i];
            order_next[i] = order_reg[i];
        end
        we    = 1'b0;
        waddr = slot_addr(order_reg[mv_dp_reg], mv_di_reg);
        wdata = mem_q;

        unique case (state_reg)
            ple_pkg::S_IDLE:
                if (start)
                begin
                    op_next  = op;
                    pos_next = PosW'(position);
                    val_next = item_value;
                end
            ple_pkg::S_DECODE:
            begin
                ok_next  = 1'b0;
                rd_next  = '0;
                p_next   = '0;
                trc_next = '0;
                case (op_reg)
                    ple_pkg::OP_READ:
                        if (pos_ge_total) pos_next = total_reg - 1'b1;
                    ple_pkg::OP_TRUNCATE:
                        if (pos_reg == total_reg) ok_next = 1'b1;
                    ple_pkg::OP_CLEAR:
                    begin
                        for (int i = 0; i < MAX_PAGES; i++) fill_next[i] = '0;
                        pu_next    = '0;
                        total_next = '0;
                        ok_next    = 1'b1;
                    end
                    default: ;
                endcase
            end
            ple_pkg::S_APPEND:
                if (app_need)
                begin
                    if (!pool_full)
                    begin
                        fill_next[pu_reg[IW-1:0]] = '0;
                        pu_next = pu_reg + 1'b1;
                    end
                end
                else
                begin
                    we    = 1'b1;
                    waddr = slot_addr(order_reg[last_ix], fill_last);
                    wdata = val_reg;
                    fill_next[last_ix] = fill_last + 1'b1;
                    total_next = total_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            ple_pkg::S_LOCATE:
                if (loc_step)
                begin
                    pos_next = pos_reg - PosW'(fill_p);
                    p_next   = p1;
                end
                else
                begin
                    mv_sp_next = p_reg;
                    mv_dp_next = p_reg;
                    if (op_reg == ple_pkg::OP_READ)
                        mv_si_next = FW'(pos_reg);
                    else if (op_reg == ple_pkg::OP_DELETE)
                    begin
                        mv_si_next  = FW'(pos_reg) + 1'b1;
                        mv_di_next  = FW'(pos_reg);
                        mv_cnt_next = fill_p - FW'(pos_reg) - 1'b1;
                        mv_dec_next = 1'b0;
                        mv_ret_next = ple_pkg::S_DEL_FIN;
                    end
                end
            ple_pkg::S_RDB:
            begin
                rd_next = mem_q;
                ok_next = 1'b1;
            end
            ple_pkg::S_MV_WR:
            begin
                we = 1'b1;
                mv_cnt_next = mv_cnt_reg - 1'b1;
                if (mv_dec_reg)
                begin
                    mv_si_next = mv_si_reg - 1'b1;
                    mv_di_next = mv_di_reg - 1'b1;
                end
                else
                begin
                    mv_si_next = mv_si_reg + 1'b1;
                    mv_di_next = mv_di_reg + 1'b1;
                end
            end
            ple_pkg::S_DEL_FIN:
            begin
                total_next = total_reg - 1'b1;
                ok_next    = 1'b1;
                if (fill_p == FW'(1) && p_reg != '0)
                begin
                    // page emptied: close the gap, return its frame to the pool
                    for (int i = 0; i < MAX_PAGES; i++)
                    begin
                        if (IW'(i) >= p_reg && (CW'(i) + CW'(1)) < pu_reg)
                        begin
                            order_next[i] = order_reg[IW'(i + 1)];
                            fill_next[i]  = fill_reg[IW'(i + 1)];
                        end
                        if (CW'(i) == pu_reg - 1'b1)
                        begin
                            order_next[i] = order_reg[p_reg];
                            fill_next[i]  = '0;
                        end
                    end
                    pu_next = pu_reg - 1'b1;
                end
                else
                    fill_next[p_reg] = fill_p - 1'b1;
            end
            ple_pkg::S_EVEN:
                if (n_even < fill_p)
                begin
                    // open room at the head of the next page
                    mv_sp_next  = p1;
                    mv_si_next  = fill_p1 - 1'b1;
                    mv_dp_next  = p1;
                    mv_di_next  = fill_p1 - 1'b1 + (fill_p - n_even);
                    mv_cnt_next = fill_p1;
                    mv_dec_next = 1'b1;
                    mv_ret_next = ple_pkg::S_EVEN2;
                end
                else if (n_even > fill_p)
                begin
                    mv_sp_next  = p1;
                    mv_si_next  = '0;
                    mv_dp_next  = p_reg;
                    mv_di_next  = fill_p;
                    mv_cnt_next = n_even - fill_p;
                    mv_dec_next = 1'b0;
                    mv_ret_next = ple_pkg::S_EVEN2;
                end
            ple_pkg::S_EVEN2:
            begin
                mv_dp_next  = p1;
                mv_di_next  = '0;
                mv_dec_next = 1'b0;
                mv_ret_next = ple_pkg::S_EVEN_FIN;
                if (n_even < fill_p)
                begin
                    mv_sp_next  = p_reg;
                    mv_si_next  = n_even;
                    mv_cnt_next = fill_p - n_even;
                end
                else
                begin
                    mv_sp_next  = p1;
                    mv_si_next  = n_even - fill_p;
                    mv_cnt_next = fill_p1 - (n_even - fill_p);
                end
            end
            ple_pkg::S_EVEN_FIN:
            begin
                fill_next[p1]    = FW'(pair_sum - (FW+1)'(n_even));
                fill_next[p_reg] = n_even;
                if (pos_reg > PosW'(n_even))
                begin
                    pos_next = pos_reg - PosW'(n_even);
                    p_next   = p1;
                end
            end
            ple_pkg::S_SPLIT:
            begin
                for (int i = 0; i < MAX_PAGES; i++)
                    if (CW'(i) > CW'(p_reg) + CW'(1) && CW'(i) <= pu_reg)
                    begin
                        order_next[i] = order_reg[IW'(i - 1)];
                        fill_next[i]  = fill_reg[IW'(i - 1)];
                    end
                order_next[p1] = order_reg[pu_reg[IW-1:0]];
                pu_next     = pu_reg + 1'b1;
                mv_sp_next  = p_reg;
                mv_si_next  = half;
                mv_dp_next  = p1;
                mv_di_next  = '0;
                mv_cnt_next = rest;
                mv_dec_next = 1'b0;
                mv_ret_next = ple_pkg::S_SPLIT_FIN;
            end
            ple_pkg::S_SPLIT_FIN:
            begin
                fill_next[p1]    = rest;
                fill_next[p_reg] = half;
                if (pos_reg > PosW'(half))
                begin
                    pos_next = pos_reg - PosW'(half);
                    p_next   = p1;
                end
            end
            ple_pkg::S_INS_SHIFT:
            begin
                mv_sp_next  = p_reg;
                mv_si_next  = fill_p - 1'b1;
                mv_dp_next  = p_reg;
                mv_di_next  = fill_p;
                mv_cnt_next = fill_p - FW'(pos_reg);
                mv_dec_next = 1'b1;
                mv_ret_next = ple_pkg::S_INS_FIN;
            end
            ple_pkg::S_INS_FIN:
            begin
                we    = 1'b1;
                waddr = slot_addr(order_reg[p_reg], FW'(pos_reg));
                wdata = val_reg;
                fill_next[p_reg] = fill_p + 1'b1;
                total_next = total_reg + 1'b1;
                ok_next    = 1'b1;
            end
            ple_pkg::S_TRUNC:
                if (tr_stop)
                begin
                    fill_next[p_reg] = FW'(pos_reg - trc_reg);
                    for (int i = 0; i < MAX_PAGES; i++)
                        if (IW'(i) > p_reg && CW'(i) < pu_reg) fill_next[i] = '0;
                    pu_next    = CW'(p_reg) + CW'(1);
                    total_next = pos_reg;
                    ok_next    = 1'b1;
                end
                else
                begin
                    trc_next = tr_sum;
                    p_next   = p1;
                end
            default: ;
        endcase
    end

    assign raddr = slot_addr(order_reg[mv_sp_reg], mv_si_reg);

    // outputs
    always_comb
    begin
        busy         = state_reg != ple_pkg::S_IDLE;
        done         = state_reg == ple_pkg::S_DONE;
        ok           = ok_reg;
        read_value   = rd_reg;
        item_count   = ple_pkg::CNT_W'(total_reg);
        pages_in_use = ple_pkg::PGC_W'(pu_reg);
        cfg_ready    = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::S_IDLE;
            cfg_reg   <= ple_pkg::CFG_RESET;
            total_reg <= '0;
            pu_reg    <= '0;
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                fill_reg[i]  <= '0;
                order_reg[i] <= IW'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid) cfg_reg <= cfg_data;
            total_reg <= total_next;
            pu_reg    <= pu_next;
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                fill_reg[i]  <= fill_next[i];
                order_reg[i] <= order_next[i];
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        p_reg      <= p_next;
        trc_reg    <= trc_next;
        ok_reg     <= ok_next;
        rd_reg     <= rd_next;
        mv_ret_reg <= mv_ret_next;
        mv_cnt_reg <= mv_cnt_next;
        mv_sp_reg  <= mv_sp_next;
        mv_si_reg  <= mv_si_next;
        mv_dp_reg  <= mv_dp_next;
        mv_di_reg  <= mv_di_next;
        mv_dec_reg <= mv_dec_next;
    end

    // page store, registered read
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        mem_q <= mem[raddr];
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("command not taken");
    a_pool: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pu_reg) <= MAX_PAGES) else $error("page pool overrun");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pu_reg == '0) |-> (total_reg == '0)) else $error("words with no page");

endmodule
